>>> hw/rtl/assert_macros.svh
// Assertion macros used by the RTL file that checks its own logic.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define KMLP_ASSERT_IMPL(name, pre, post) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
    else $error("assertion failed");

// Next-cycle implication, checked outside reset.
`define KMLP_ASSERT_NEXT(name, pre, post) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
    else $error("assertion failed");

`endif

>>> hw/rtl/kmlp_pkg.sv
// Package: payload types, register map and protocol constants of the keyboard link unit.
`timescale 1ns / 1ps
`default_nettype none

package kmlp_pkg;

  localparam int QUEUE_DEPTH_DEF = 8;
  localparam int CFG_AW = 4;
  localparam int CFG_DW = 32;

  localparam logic [1:0] REG_ACK_TIMEOUT = 2'd0;
  localparam logic [1:0] REG_HS_TIMEOUT  = 2'd1;
  localparam logic [1:0] REG_KEYBOARD_ID = 2'd2;

  localparam logic [7:0] ACK_TIMEOUT_RST = 8'd10;
  localparam logic [7:0] HS_TIMEOUT_RST  = 8'd20;
  localparam logic [5:0] KEYBOARD_ID_RST = 6'd1;

  localparam logic [1:0] CMD_KEY   = 2'd0;
  localparam logic [1:0] CMD_MOUSE = 2'd1;
  localparam logic [1:0] CMD_RX    = 2'd2;
  localparam logic [1:0] CMD_TICK  = 2'd3;

  localparam logic [7:0] BYTE_HRST     = 8'hff;
  localparam logic [7:0] BYTE_RAK1     = 8'hfe;
  localparam logic [7:0] BYTE_RAK2     = 8'hfd;
  localparam logic [7:0] BYTE_RQID     = 8'h20;
  localparam logic [7:0] BYTE_ID_PFX   = 8'h80;
  localparam logic [7:0] BYTE_PRESS    = 8'hc0;
  localparam logic [7:0] BYTE_RELEASE  = 8'hd0;
  localparam logic [7:0] BYTE_SMAK     = 8'h3f;
  localparam logic [7:0] BYTE_ACK_LO   = 8'h30;
  localparam logic [7:0] BYTE_ACK_HI   = 8'h33;
  localparam logic [3:0] BTN_KEY_ROW   = 4'h7;
  localparam logic [3:0] BTN_ONE_COL   = 4'h0;
  localparam logic [3:0] BTN_TWO_COL   = 4'h1;

  typedef struct packed {
    logic [1:0]        command;
    logic [3:0]        key_row;
    logic [3:0]        key_col;
    logic              key_up;
    logic [1:0]        buttons;
    logic signed [7:0] move_x;
    logic signed [7:0] move_y;
    logic [7:0]        rx_byte;
  } in_t;

  typedef struct packed {
    logic       tx_valid;
    logic [7:0] tx_byte;
    logic [2:0] link_status;
    logic       scan_enabled;
    logic       mouse_enabled;
    logic       queue_overflow;
  } out_t;

endpackage

`default_nettype wire

>>> hw/rtl/keyboard_mouse_link_protocol_unit.sv
// Top level: keyboard side of the two-byte acknowledged host link.
//
// Input channel (in_valid/in_ready/in_data): one transaction per key event, mouse
// event, received host byte or millisecond tick. Output channel (out_valid/
// out_ready/out_data): exactly one result transaction per input transaction,
// carrying at most one transmitted byte plus link state and flags.
// The result is registered into the result buffer when the input is accepted.
// Throughput is one transaction per cycle while in_ready is high. A transaction that
// places k > 1 bytes into the pending queue holds in_ready low until all of them are
// written, since the queue memory has a single write port (one entry per cycle).
// The pending queue is a synchronous memory with a registered read; its head is
// prefetched every cycle, with write forwarding when the head is being written.
// A two-entry result buffer lets the block take new transactions while one
// result waits; when both entries are full, in_ready drops until out_ready.
// Reset (rst_n low, synchronous) restores the control registers to reset values,
// puts the link in the rak1 state with the timer expired, so the first tick
// sends the reset byte; the queue memory needs no clearing pass.
// Configuration is written over the APB-style port; the user must do so only while
// no transaction is in flight, as the block itself does not enforce it.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module keyboard_mouse_link_protocol_unit #(
  parameter int QUEUE_DEPTH = kmlp_pkg::QUEUE_DEPTH_DEF
) (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       in_valid,
  output logic                            in_ready,
  input  wire kmlp_pkg::in_t              in_data,
  output logic                            out_valid,
  input  wire logic                       out_ready,
  output kmlp_pkg::out_t                  out_data,
  input  wire logic                       cfg_psel,
  input  wire logic                       cfg_penable,
  input  wire logic                       cfg_pwrite,
  input  wire logic [kmlp_pkg::CFG_AW-1:0] cfg_paddr,
  input  wire logic [kmlp_pkg::CFG_DW-1:0] cfg_pwdata,
  output logic [kmlp_pkg::CFG_DW-1:0]     cfg_prdata,
  output logic                            cfg_pready
);

  localparam int AW   = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CMPW = AW + 3;

  typedef enum logic [2:0] {
    LS_HRST  = 3'd0,
    LS_RAK1  = 3'd1,
    LS_RAK2  = 3'd2,
    LS_IDLE  = 3'd3,
    LS_WAIT1 = 3'd4,
    LS_WAIT2 = 3'd5
  } link_state_t;

  typedef struct packed {
    link_state_t st;
    logic [7:0]  data;
  } q_entry_t;

  function automatic logic signed [6:0] clamp7(input logic signed [8:0] v);
    logic signed [6:0] r;
    if (v > 9'sd63) r = 7'sd63;
    else if (v < -9'sd64) r = -7'sd64;
    else r = v[6:0];
    return r;
  endfunction

  // Configuration registers
  logic [7:0] ack_ticks_r;
  logic [7:0] hs_ticks_r;
  logic [5:0] kbd_id_r;
  logic       cfg_we;
  logic [1:0] cfg_idx;

  // Control state
  link_state_t     st_r, st_nxt;
  logic [7:0]      tc_r, tc_nxt;
  logic [AW-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [AW-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [AW-1:0]   q_cnt_r, q_cnt_nxt;
  logic signed [6:0] ax_r, ax_nxt;
  logic signed [6:0] ay_r, ay_nxt;
  logic [1:0]      flags_r, flags_nxt;
  logic [1:0]      lb_r, lb_nxt;
  logic [2:0]      pend_left_r, pend_left_nxt;
  logic [1:0]      out_cnt_r, out_cnt_nxt;
  logic            fwd_r;

  // Queue memory and payload
  q_entry_t        q_mem [QUEUE_DEPTH];
  q_entry_t        q_rdata_r;
  q_entry_t        fwd_data_r;
  q_entry_t        q_head;
  logic            q_we;
  q_entry_t        q_wd;
  q_entry_t        pend_r [5];
  kmlp_pkg::out_t  out_slot_r [2];

  // Item evaluation
  logic            acc;
  logic            pop;
  q_entry_t        lst [8];
  logic [2:0]      nlst;
  link_state_t     st_pre;
  logic            use_hs;
  logic            drain;
  logic            q_clr;
  logic            tx;
  logic [2:0]      nq;
  logic [2:0]      n_wr;
  logic [CMPW-1:0] q_free;
  logic            drop;
  kmlp_pkg::out_t  res;

  assign cfg_pready = 1'b1;
  assign cfg_idx    = cfg_paddr[3:2];
  assign cfg_we     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;

  always_comb begin
    case (cfg_idx)
      kmlp_pkg::REG_ACK_TIMEOUT: cfg_prdata = {24'd0, ack_ticks_r};
      kmlp_pkg::REG_HS_TIMEOUT:  cfg_prdata = {24'd0, hs_ticks_r};
      kmlp_pkg::REG_KEYBOARD_ID: cfg_prdata = {26'd0, kbd_id_r};
      default:                   cfg_prdata = '0;
    endcase
  end

  assign in_ready  = (out_cnt_r != 2'd2) && (pend_left_r == 3'd0);
  assign acc       = in_valid && in_ready;
  assign out_valid = (out_cnt_r != 2'd0);
  assign pop       = out_valid && out_ready;
  assign out_data  = out_slot_r[0];
  assign q_head    = fwd_r ? fwd_data_r : q_rdata_r;

  // Per-transaction decisions: builds the ordered list of bytes to send
  always_comb begin
    logic [7:0]        pfx;
    logic [7:0]        tcd;
    logic signed [8:0] sx;
    logic signed [8:0] sy;
    logic signed [6:0] ax_c;
    logic signed [6:0] ay_c;
    logic              g_v [3];
    q_entry_t          g_e [3][2];
    logic [2:0]        pos;
    logic              hs_st;
    logic              wait_st;

    st_nxt    = st_r;
    tc_nxt    = tc_r;
    ax_nxt    = ax_r;
    ay_nxt    = ay_r;
    flags_nxt = flags_r;
    lb_nxt    = lb_r;
    st_pre    = st_r;
    use_hs    = 1'b0;
    drain     = 1'b0;
    q_clr     = 1'b0;
    nlst      = 3'd0;
    pos       = 3'd0;
    for (int i = 0; i < 8; i++) lst[i] = '0;
    for (int g = 0; g < 3; g++) begin
      g_v[g]    = 1'b0;
      g_e[g][0] = '0;
      g_e[g][1] = '0;
    end
    hs_st   = (st_r == LS_HRST) || (st_r == LS_RAK1) || (st_r == LS_RAK2);
    wait_st = (st_r == LS_WAIT1) || (st_r == LS_WAIT2);
    pfx     = in_data.key_up ? kmlp_pkg::BYTE_RELEASE : kmlp_pkg::BYTE_PRESS;
    tcd     = (tc_r != 8'd0) ? tc_r - 8'd1 : tc_r;
    sx      = {{2{ax_r[6]}}, ax_r} + {in_data.move_x[7], in_data.move_x};
    sy      = {{2{ay_r[6]}}, ay_r} - {in_data.move_y[7], in_data.move_y};
    ax_c    = clamp7(sx);
    ay_c    = clamp7(sy);

    case (in_data.command)
      kmlp_pkg::CMD_KEY: begin
        if (!hs_st && flags_r[0]) begin
          lst[0] = '{st: LS_WAIT1, data: pfx | {4'd0, in_data.key_row}};
          lst[1] = '{st: LS_WAIT2, data: pfx | {4'd0, in_data.key_col}};
          nlst   = 3'd2;
        end
      end
      kmlp_pkg::CMD_MOUSE: begin
        ax_nxt = ax_c;
        ay_nxt = ay_c;
        if (!hs_st) begin
          if (flags_r[1] && (ax_c != 7'sd0 || ay_c != 7'sd0) && st_r == LS_IDLE) begin
            g_v[0]    = 1'b1;
            g_e[0][0] = '{st: LS_WAIT1, data: {1'b0, ax_c}};
            g_e[0][1] = '{st: LS_WAIT2, data: {1'b0, ay_c}};
            ax_nxt    = 7'sd0;
            ay_nxt    = 7'sd0;
          end
          if (flags_r[0]) begin
            if (in_data.buttons[0] != lb_r[0]) begin
              g_v[1]    = 1'b1;
              g_e[1][0] = '{st: LS_WAIT1, data: (in_data.buttons[0] ? kmlp_pkg::BYTE_PRESS
                            : kmlp_pkg::BYTE_RELEASE) | {4'd0, kmlp_pkg::BTN_KEY_ROW}};
              g_e[1][1] = '{st: LS_WAIT2, data: (in_data.buttons[0] ? kmlp_pkg::BYTE_PRESS
                            : kmlp_pkg::BYTE_RELEASE) | {4'd0, kmlp_pkg::BTN_ONE_COL}};
            end
            if (in_data.buttons[1] != lb_r[1]) begin
              g_v[2]    = 1'b1;
              g_e[2][0] = '{st: LS_WAIT1, data: (in_data.buttons[1] ? kmlp_pkg::BYTE_PRESS
                            : kmlp_pkg::BYTE_RELEASE) | {4'd0, kmlp_pkg::BTN_KEY_ROW}};
              g_e[2][1] = '{st: LS_WAIT2, data: (in_data.buttons[1] ? kmlp_pkg::BYTE_PRESS
                            : kmlp_pkg::BYTE_RELEASE) | {4'd0, kmlp_pkg::BTN_TWO_COL}};
            end
            lb_nxt = in_data.buttons;
          end
          for (int g = 0; g < 3; g++) begin
            if (g_v[g]) begin
              lst[pos]              = g_e[g][0];
              lst[3'(pos + 3'd1)]   = g_e[g][1];
              pos                   = 3'(pos + 3'd2);
            end
          end
          nlst = pos;
        end
      end
      kmlp_pkg::CMD_RX: begin
        if (in_data.rx_byte == kmlp_pkg::BYTE_HRST) begin
          q_clr     = 1'b1;
          ax_nxt    = 7'sd0;
          ay_nxt    = 7'sd0;
          flags_nxt = 2'd0;
          st_pre    = LS_HRST;
          lst[0]    = '{st: LS_RAK1, data: kmlp_pkg::BYTE_HRST};
          nlst      = 3'd1;
          use_hs    = 1'b1;
        end else if (in_data.rx_byte == kmlp_pkg::BYTE_RAK1) begin
          if (st_r == LS_RAK1) begin
            lst[0] = '{st: LS_RAK2, data: kmlp_pkg::BYTE_RAK1};
            nlst   = 3'd1;
            use_hs = 1'b1;
          end else begin
            st_nxt = LS_HRST;
          end
        end else if (in_data.rx_byte == kmlp_pkg::BYTE_RAK2) begin
          if (st_r == LS_RAK2) begin
            lst[0] = '{st: LS_IDLE, data: kmlp_pkg::BYTE_RAK2};
            nlst   = 3'd1;
            use_hs = 1'b1;
          end else begin
            st_nxt = LS_HRST;
          end
        end else if (in_data.rx_byte == kmlp_pkg::BYTE_RQID) begin
          lst[0] = '{st: LS_IDLE, data: kmlp_pkg::BYTE_ID_PFX | {2'd0, kbd_id_r}};
          nlst   = 3'd1;
        end else if (in_data.rx_byte == kmlp_pkg::BYTE_SMAK ||
                     (in_data.rx_byte >= kmlp_pkg::BYTE_ACK_LO &&
                      in_data.rx_byte <= kmlp_pkg::BYTE_ACK_HI)) begin
          if (in_data.rx_byte != kmlp_pkg::BYTE_SMAK) flags_nxt = in_data.rx_byte[1:0];
          st_nxt = LS_IDLE;
          st_pre = LS_IDLE;
          if (q_cnt_r != '0) begin
            drain  = 1'b1;
            lst[0] = q_head;
            nlst   = 3'd1;
          end
        end
      end
      default: begin
        tc_nxt = tcd;
        if (wait_st && tcd == 8'd0) begin
          st_nxt = LS_IDLE;
          st_pre = LS_IDLE;
        end
        if (hs_st && tcd == 8'd0) begin
          lst[0] = '{st: LS_RAK1, data: kmlp_pkg::BYTE_HRST};
          nlst   = 3'd1;
          use_hs = 1'b1;
        end
      end
    endcase

    tx = (nlst != 3'd0) && (st_pre != LS_WAIT1) && (st_pre != LS_WAIT2);
    if (tx) begin
      st_nxt = lst[0].st;
      tc_nxt = use_hs ? hs_ticks_r : ack_ticks_r;
    end
  end

  // Queue admission: bytes that are not transmitted go to the queue while it has room
  always_comb begin
    nq     = 3'(nlst - {2'd0, tx});
    q_free = CMPW'(QUEUE_DEPTH - 1) - CMPW'(q_cnt_r);
    drop   = CMPW'(nq) > q_free;
    n_wr   = drop ? q_free[2:0] : nq;

    res.tx_valid       = tx;
    res.tx_byte        = tx ? lst[0].data : 8'd0;
    res.link_status    = st_nxt;
    res.scan_enabled   = flags_nxt[0];
    res.mouse_enabled  = flags_nxt[1];
    res.queue_overflow = drop;

    q_we = (acc && n_wr != 3'd0) || (pend_left_r != 3'd0);
    q_wd = (pend_left_r != 3'd0) ? pend_r[0] : lst[{2'd0, tx}];

    pend_left_nxt = pend_left_r;
    if (acc && n_wr != 3'd0) pend_left_nxt = 3'(n_wr - 3'd1);
    else if (pend_left_r != 3'd0) pend_left_nxt = 3'(pend_left_r - 3'd1);

    rd_ptr_nxt = rd_ptr_r;
    wr_ptr_nxt = wr_ptr_r;
    q_cnt_nxt  = q_cnt_r;
    if (acc && q_clr) begin
      rd_ptr_nxt = '0;
      wr_ptr_nxt = '0;
      q_cnt_nxt  = '0;
    end else if (q_we) begin
      wr_ptr_nxt = (wr_ptr_r == AW'(QUEUE_DEPTH - 1)) ? '0 : AW'(wr_ptr_r + 1'b1);
      q_cnt_nxt  = AW'(q_cnt_r + 1'b1);
    end else if (acc && drain) begin
      rd_ptr_nxt = (rd_ptr_r == AW'(QUEUE_DEPTH - 1)) ? '0 : AW'(rd_ptr_r + 1'b1);
      q_cnt_nxt  = AW'(q_cnt_r - 1'b1);
    end

    out_cnt_nxt = 2'(out_cnt_r + {1'b0, acc} - {1'b0, pop});
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ack_ticks_r <= kmlp_pkg::ACK_TIMEOUT_RST;
      hs_ticks_r  <= kmlp_pkg::HS_TIMEOUT_RST;
      kbd_id_r    <= kmlp_pkg::KEYBOARD_ID_RST;
      st_r        <= LS_RAK1;
      tc_r        <= 8'd0;
      rd_ptr_r    <= '0;
      wr_ptr_r    <= '0;
      q_cnt_r     <= '0;
      ax_r        <= 7'sd0;
      ay_r        <= 7'sd0;
      flags_r     <= 2'd0;
      lb_r        <= 2'd0;
      pend_left_r <= 3'd0;
      out_cnt_r   <= 2'd0;
      fwd_r       <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (cfg_idx)
          kmlp_pkg::REG_ACK_TIMEOUT: ack_ticks_r <= cfg_pwdata[7:0];
          kmlp_pkg::REG_HS_TIMEOUT:  hs_ticks_r  <= cfg_pwdata[7:0];
          kmlp_pkg::REG_KEYBOARD_ID: kbd_id_r    <= cfg_pwdata[5:0];
          default: ;
        endcase
      end
      if (acc) begin
        st_r    <= st_nxt;
        tc_r    <= tc_nxt;
        ax_r    <= ax_nxt;
        ay_r    <= ay_nxt;
        flags_r <= flags_nxt;
        lb_r    <= lb_nxt;
      end
      rd_ptr_r    <= rd_ptr_nxt;
      wr_ptr_r    <= wr_ptr_nxt;
      q_cnt_r     <= q_cnt_nxt;
      pend_left_r <= pend_left_nxt;
      out_cnt_r   <= out_cnt_nxt;
      fwd_r       <= q_we && (wr_ptr_r == rd_ptr_nxt);
    end
  end

  // Pending queue memory; head is prefetched at the next read pointer
  always_ff @(posedge clk) begin
    if (q_we) q_mem[wr_ptr_r] <= q_wd;
    q_rdata_r  <= q_mem[rd_ptr_nxt];
    fwd_data_r <= q_wd;
  end

  // Payload registers: queued-entry backlog and result buffer
  always_ff @(posedge clk) begin
    if (acc) begin
      for (int i = 0; i < 5; i++) pend_r[i] <= lst[3'(i + 1 + int'(tx))];
    end else if (pend_left_r != 3'd0) begin
      for (int i = 0; i < 4; i++) pend_r[i] <= pend_r[i + 1];
    end
    if (acc && (out_cnt_r == 2'd0 || (out_cnt_r == 2'd1 && pop))) begin
      out_slot_r[0] <= res;
    end else if (pop && out_cnt_r == 2'd2) begin
      out_slot_r[0] <= out_slot_r[1];
    end
    if (acc && out_cnt_r == 2'd1 && !pop) out_slot_r[1] <= res;
  end

  `KMLP_ASSERT_IMPL(a_q_cnt_max, 1'b1, q_cnt_r <= AW'(QUEUE_DEPTH - 1))
  `KMLP_ASSERT_NEXT(a_pend_fill, pend_left_r != 3'd0, q_cnt_r == AW'($past(q_cnt_r) + 1'b1))
  `KMLP_ASSERT_IMPL(a_out_cnt, 1'b1, out_cnt_r <= 2'd2)
  `KMLP_ASSERT_NEXT(a_drain_pop, acc && drain, q_cnt_r == AW'($past(q_cnt_r) - 1'b1))

endmodule

`default_nettype wire

>>> sim/kmlp_link_checker.sv
// Checker: predicts each result transaction of the keyboard link unit and compares it.
`timescale 1ns / 1ps

module kmlp_link_checker
  import kmlp_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  input  wire logic              in_ready,
  input  wire in_t               in_data,
  input  wire logic              out_valid,
  input  wire logic              out_ready,
  input  wire out_t              out_data,
  input  wire logic              cfg_psel,
  input  wire logic              cfg_penable,
  input  wire logic              cfg_pwrite,
  input  wire logic [CFG_AW-1:0] cfg_paddr,
  input  wire logic [CFG_DW-1:0] cfg_pwdata,
  input  wire logic [CFG_DW-1:0] cfg_prdata,
  input  wire logic              cfg_pready,
  output int                     errors,
  output int                     exp_left,
  output int                     checked,
  output int                     bytes_sent,
  output int                     drops
);

  typedef enum logic [2:0] {
    LS_HRST, LS_RAK1, LS_RAK2, LS_IDLE, LS_WAIT1, LS_WAIT2
  } link_e;

  localparam int QDEPTH = QUEUE_DEPTH_DEF;

  logic [7:0]  ack_ticks;
  logic [7:0]  hs_ticks;
  logic [5:0]  kb_id;
  logic [2:0]  link_st;
  logic [7:0]  tmo;
  logic [10:0] tx_fifo [QDEPTH];
  int          rd_ptr;
  int          wr_ptr;
  int          acc_x;
  int          acc_y;
  logic        scan_en;
  logic        mouse_en;
  logic [1:0]  last_btn;
  logic        tx_now;
  logic [7:0]  tx_val;
  logic        drop_now;
  out_t        pending_reports [$];

  function automatic int ring_next(input int p);
    return (p + 1 >= QDEPTH) ? 0 : p + 1;
  endfunction

  function automatic int sat7(input int v);
    if (v > 63) return 63;
    if (v < -64) return -64;
    return v;
  endfunction

  function automatic bit is_waiting();
    return link_st == LS_WAIT1 || link_st == LS_WAIT2;
  endfunction

  function automatic void emit(input logic [2:0] st, input logic [7:0] b);
    tx_now  = 1'b1;
    tx_val  = b;
    link_st = st;
    tmo     = ack_ticks;
  endfunction

  function automatic void send(input logic [2:0] st, input logic [7:0] b);
    if (!is_waiting()) begin
      emit(st, b);
    end else if (ring_next(wr_ptr) == rd_ptr) begin
      drop_now = 1'b1;
    end else begin
      tx_fifo[wr_ptr] = {st, b};
      wr_ptr = ring_next(wr_ptr);
    end
  endfunction

  function automatic void drain_head();
    if (rd_ptr != wr_ptr) begin
      emit(tx_fifo[rd_ptr][10:8], tx_fifo[rd_ptr][7:0]);
      rd_ptr = ring_next(rd_ptr);
    end
  endfunction

  function automatic void on_key(input in_t it);
    logic [7:0] pfx;
    if (link_st < LS_IDLE || !scan_en) return;
    pfx = it.key_up ? BYTE_RELEASE : BYTE_PRESS;
    send(LS_WAIT1, pfx | {4'h0, it.key_row});
    send(LS_WAIT2, pfx | {4'h0, it.key_col});
  endfunction

  function automatic void on_mouse(input in_t it);
    logic [7:0] pfx;
    acc_x = sat7(acc_x + int'($signed(it.move_x)));
    acc_y = sat7(acc_y - int'($signed(it.move_y)));
    if (link_st < LS_IDLE) return;
    if (mouse_en && (acc_x != 0 || acc_y != 0) && link_st == LS_IDLE) begin
      send(LS_WAIT1, 8'(acc_x & 'h7f));
      send(LS_WAIT2, 8'(acc_y & 'h7f));
      acc_x = 0;
      acc_y = 0;
    end
    if (scan_en) begin
      if (it.buttons[0] != last_btn[0]) begin
        pfx = it.buttons[0] ? BYTE_PRESS : BYTE_RELEASE;
        send(LS_WAIT1, pfx | {4'h0, BTN_KEY_ROW});
        send(LS_WAIT2, pfx | {4'h0, BTN_ONE_COL});
      end
      if (it.buttons[1] != last_btn[1]) begin
        pfx = it.buttons[1] ? BYTE_PRESS : BYTE_RELEASE;
        send(LS_WAIT1, pfx | {4'h0, BTN_KEY_ROW});
        send(LS_WAIT2, pfx | {4'h0, BTN_TWO_COL});
      end
      last_btn = it.buttons;
    end
  endfunction

  function automatic void on_host_byte(input logic [7:0] d);
    if (d == BYTE_HRST) begin
      rd_ptr   = 0;
      wr_ptr   = 0;
      acc_x    = 0;
      acc_y    = 0;
      scan_en  = 1'b0;
      mouse_en = 1'b0;
      link_st  = LS_HRST;
      send(LS_RAK1, BYTE_HRST);
      tmo = hs_ticks;
    end else if (d == BYTE_RAK1) begin
      if (link_st == LS_RAK1) begin
        send(LS_RAK2, BYTE_RAK1);
        tmo = hs_ticks;
      end else begin
        link_st = LS_HRST;
      end
    end else if (d == BYTE_RAK2) begin
      if (link_st == LS_RAK2) begin
        send(LS_IDLE, BYTE_RAK2);
        tmo = hs_ticks;
      end else begin
        link_st = LS_HRST;
      end
    end else if (d == BYTE_RQID) begin
      send(LS_IDLE, BYTE_ID_PFX | {2'b00, kb_id});
    end else if (d == BYTE_SMAK || (d >= BYTE_ACK_LO && d <= BYTE_ACK_HI)) begin
      if (d != BYTE_SMAK) begin
        scan_en  = d[0];
        mouse_en = d[1];
      end
      link_st = LS_IDLE;
      drain_head();
    end
  endfunction

  function automatic void on_tick();
    logic expired;
    if (tmo != 8'd0) tmo = tmo - 8'd1;
    expired = (tmo == 8'd0);
    if (is_waiting() && expired) link_st = LS_IDLE;
    if (link_st < LS_IDLE && expired) begin
      send(LS_RAK1, BYTE_HRST);
      tmo = hs_ticks;
    end
  endfunction

  function automatic out_t next_link_report(input in_t it);
    out_t r;
    tx_now   = 1'b0;
    tx_val   = 8'h00;
    drop_now = 1'b0;
    case (it.command)
      CMD_KEY:   on_key(it);
      CMD_MOUSE: on_mouse(it);
      CMD_RX:    on_host_byte(it.rx_byte);
      default:   on_tick();
    endcase
    r.tx_valid       = tx_now;
    r.tx_byte        = tx_now ? tx_val : 8'h00;
    r.link_status    = link_st;
    r.scan_enabled   = scan_en;
    r.mouse_enabled  = mouse_en;
    r.queue_overflow = drop_now;
    return r;
  endfunction

  function automatic void reset_link_model();
    ack_ticks = ACK_TIMEOUT_RST;
    hs_ticks  = HS_TIMEOUT_RST;
    kb_id     = KEYBOARD_ID_RST;
    link_st   = LS_RAK1;
    tmo       = 8'd0;
    rd_ptr    = 0;
    wr_ptr    = 0;
    acc_x     = 0;
    acc_y     = 0;
    scan_en   = 1'b0;
    mouse_en  = 1'b0;
    last_btn  = 2'b00;
  endfunction

  function automatic string show(input out_t r);
    return $sformatf("tx=%0b byte=%02h link=%0d scan=%0b mouse=%0b ovf=%0b",
                     r.tx_valid, r.tx_byte, r.link_status, r.scan_enabled,
                     r.mouse_enabled, r.queue_overflow);
  endfunction

  function automatic void flag_error(input string msg);
    errors++;
    if (errors <= 10) $display("%0t mismatch: %s", $realtime, msg);
  endfunction

  always @(posedge clk) begin
    out_t              got;
    out_t              want;
    logic [1:0]        idx;
    logic [CFG_DW-1:0] reg_exp;
    bit                known;
    if (!rst_n) begin
      reset_link_model();
      pending_reports.delete();
    end else begin
      idx = cfg_paddr[CFG_AW-1:2];
      if (cfg_psel && cfg_penable && cfg_pready) begin
        known = 1'b1;
        case (idx)
          REG_ACK_TIMEOUT: reg_exp = CFG_DW'(ack_ticks);
          REG_HS_TIMEOUT:  reg_exp = CFG_DW'(hs_ticks);
          REG_KEYBOARD_ID: reg_exp = CFG_DW'(kb_id);
          default: begin
            reg_exp = '0;
            known   = 1'b0;
          end
        endcase
        if (cfg_pwrite) begin
          case (idx)
            REG_ACK_TIMEOUT: ack_ticks = cfg_pwdata[7:0];
            REG_HS_TIMEOUT:  hs_ticks  = cfg_pwdata[7:0];
            REG_KEYBOARD_ID: kb_id     = cfg_pwdata[5:0];
            default: ;
          endcase
        end else if (known && cfg_prdata !== reg_exp) begin
          flag_error($sformatf("register read at %0h: expected %0h, got %0h",
                               cfg_paddr, reg_exp, cfg_prdata));
        end
      end
      if (out_valid && out_ready) begin
        got = out_data;
        if (got.tx_valid === 1'b1) bytes_sent++;
        if (got.queue_overflow === 1'b1) drops++;
        if (pending_reports.size() == 0) begin
          flag_error($sformatf("result with none expected: %s", show(got)));
        end else begin
          want = pending_reports.pop_front();
          checked++;
          if (got.tx_valid !== want.tx_valid || got.tx_byte !== want.tx_byte ||
              got.link_status !== want.link_status ||
              got.scan_enabled !== want.scan_enabled ||
              got.mouse_enabled !== want.mouse_enabled ||
              got.queue_overflow !== want.queue_overflow)
            flag_error($sformatf("expected %s, got %s", show(want), show(got)));
        end
      end
      if (in_valid && in_ready) pending_reports.push_back(next_link_report(in_data));
    end
    exp_left <= pending_reports.size();
  end

endmodule

>>> sim/tb.sv
// Testbench top: drives transactions and register traffic into the link unit, gives the verdict.
`timescale 1ns / 1ps

module tb;
  import kmlp_pkg::*;

  localparam int         HOLD_CYCLES  = 300;
  localparam int         NSET         = 5;
  localparam int         PHASE_ITEMS  = 205;
  localparam logic [1:0] REG_UNUSED   = 2'd3;
  localparam logic [7:0] BYTE_UNKNOWN = 8'h55;

  logic              clk         = 1'b0;
  logic              rst_n       = 1'b0;
  logic              in_valid    = 1'b0;
  logic              in_ready;
  in_t               in_data     = '0;
  logic              out_valid;
  logic              out_ready   = 1'b0;
  out_t              out_data;
  logic              cfg_psel    = 1'b0;
  logic              cfg_penable = 1'b0;
  logic              cfg_pwrite  = 1'b0;
  logic [CFG_AW-1:0] cfg_paddr   = '0;
  logic [CFG_DW-1:0] cfg_pwdata  = '0;
  logic [CFG_DW-1:0] cfg_prdata;
  logic              cfg_pready;

  int   errors;
  int   exp_left;
  int   checked;
  int   bytes_sent;
  int   drops;
  int   sent     = 0;
  int   hold_req = 0;
  logic steady   = 1'b0;

  int ack_set [NSET] = '{1, 255, 3, 2, 10};
  int hs_set  [NSET] = '{1, 255, 5, 2, 20};
  int id_set  [NSET] = '{0, 63, 42, 21, 1};

  keyboard_mouse_link_protocol_unit dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
    .cfg_psel(cfg_psel), .cfg_penable(cfg_penable), .cfg_pwrite(cfg_pwrite),
    .cfg_paddr(cfg_paddr), .cfg_pwdata(cfg_pwdata), .cfg_prdata(cfg_prdata),
    .cfg_pready(cfg_pready)
  );

  kmlp_link_checker chk (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
    .cfg_psel(cfg_psel), .cfg_penable(cfg_penable), .cfg_pwrite(cfg_pwrite),
    .cfg_paddr(cfg_paddr), .cfg_pwdata(cfg_pwdata), .cfg_prdata(cfg_prdata),
    .cfg_pready(cfg_pready),
    .errors(errors), .exp_left(exp_left), .checked(checked),
    .bytes_sent(bytes_sent), .drops(drops)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  initial begin
    #200000;
    $display("RESULT: ERROR");
    $finish;
  end

  // result side: random stalls or steady ready, a long hold-off on request
  initial begin : result_side
    int seen;
    seen = 0;
    forever begin
      @(posedge clk);
      if (hold_req != seen) begin
        seen = hold_req;
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end else if (steady) begin
        out_ready <= 1'b1;
      end else begin
        out_ready <= ($urandom_range(0, 99) >= 12);
      end
    end
  end

  function automatic in_t base_item(input logic [1:0] cmd);
    logic [63:0] r;
    in_t         it;
    r  = {$urandom, $urandom};
    it = r[$bits(in_t)-1:0];
    it.command = cmd;
    return it;
  endfunction

  function automatic logic [7:0] ack_byte();
    if ($urandom_range(0, 3) != 0) return BYTE_ACK_HI;
    return BYTE_ACK_LO + 8'($urandom_range(0, 2));
  endfunction

  function automatic in_t rand_item();
    in_t it;
    int  w;
    w = $urandom_range(0, 99);
    if (w < 30) begin
      it = base_item(CMD_KEY);
    end else if (w < 55) begin
      it = base_item(CMD_MOUSE);
      if ($urandom_range(0, 3) != 0) begin
        it.move_x = 8'($urandom_range(0, 8)) - 8'd4;
        it.move_y = 8'($urandom_range(0, 8)) - 8'd4;
      end
    end else if (w < 72) begin
      it = base_item(CMD_TICK);
    end else begin
      it = base_item(CMD_RX);
      w = $urandom_range(0, 99);
      if (w < 45)      it.rx_byte = BYTE_SMAK;
      else if (w < 80) it.rx_byte = ack_byte();
      else if (w < 88) it.rx_byte = BYTE_RQID;
      else if (w < 90) it.rx_byte = BYTE_HRST;
      else if (w < 92) it.rx_byte = BYTE_RAK1;
      else if (w < 94) it.rx_byte = BYTE_RAK2;
    end
    return it;
  endfunction

  task automatic push_item(input in_t it);
    in_data  <= it;
    in_valid <= 1'b1;
    do @(posedge clk); while (!in_ready);
    sent++;
    if (!steady && $urandom_range(0, 99) < 10) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 2)) @(posedge clk);
    end
  endtask

  task automatic rx_push(input logic [7:0] b);
    in_t it;
    it = base_item(CMD_RX);
    it.rx_byte = b;
    push_item(it);
  endtask

  task automatic wait_drained();
    do @(posedge clk); while (exp_left != 0);
  endtask

  task automatic apb_xfer(input logic wr, input logic [CFG_AW-1:0] addr,
                          input logic [CFG_DW-1:0] data);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= wr;
    cfg_paddr   <= addr;
    cfg_pwdata  <= data;
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    @(posedge clk);
  endtask

  task automatic read_back();
    apb_xfer(1'b0, {REG_ACK_TIMEOUT, 2'b00}, '0);
    apb_xfer(1'b0, {REG_HS_TIMEOUT, 2'b00}, '0);
    apb_xfer(1'b0, {REG_KEYBOARD_ID, 2'b00}, '0);
  endtask

  task automatic configure(input logic [7:0] ack, input logic [7:0] hs, input logic [5:0] id);
    logic [CFG_DW-1:0] r;
    r = $urandom;
    r[7:0] = ack;
    apb_xfer(1'b1, {REG_ACK_TIMEOUT, 2'b00}, r);
    r = $urandom;
    r[7:0] = hs;
    apb_xfer(1'b1, {REG_HS_TIMEOUT, 2'b00}, r);
    r = $urandom;
    r[5:0] = id;
    apb_xfer(1'b1, {REG_KEYBOARD_ID, 2'b00}, r);
    read_back();
  endtask

  // reset handshake, mostly well formed
  task automatic link_up();
    int w;
    w = $urandom_range(0, 99);
    if (w < 12) begin
      repeat ($urandom_range(1, 24)) push_item(base_item(CMD_TICK));
    end else if (w < 20) begin
      rx_push(BYTE_HRST);
      rx_push(w[0] ? BYTE_RAK2 : BYTE_RAK1);
      rx_push(BYTE_RAK1);
    end else begin
      rx_push(BYTE_HRST);
      rx_push(BYTE_RAK1);
      rx_push(BYTE_RAK2);
    end
    if (w >= 20 || $urandom_range(0, 1) != 0) rx_push(ack_byte());
  endtask

  initial begin : stimulus
    in_t it;
    int  n;
    bit  held;
    bit  paused;
    held   = 1'b0;
    paused = 1'b0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    read_back();

    // directed part
    push_item(base_item(CMD_TICK));
    push_item(base_item(CMD_KEY));
    it = base_item(CMD_MOUSE);
    it.move_x = 8'h7f;
    it.move_y = 8'h80;
    push_item(it);
    rx_push(BYTE_RAK2);
    rx_push(BYTE_RAK1);
    rx_push(BYTE_HRST);
    rx_push(BYTE_RAK1);
    rx_push(BYTE_RAK2);
    rx_push(BYTE_RQID);
    push_item(base_item(CMD_KEY));
    it = base_item(CMD_MOUSE);
    it.buttons = 2'b11;
    push_item(it);
    rx_push(BYTE_ACK_LO);
    rx_push(BYTE_ACK_HI);
    it = base_item(CMD_MOUSE);
    it.buttons = 2'b11;
    it.move_x  = 8'h80;
    it.move_y  = 8'h7f;
    push_item(it);
    it = base_item(CMD_KEY);
    it.key_row = 4'hf;
    it.key_col = 4'hf;
    it.key_up  = 1'b1;
    push_item(it);
    it = base_item(CMD_KEY);
    it.key_row = 4'h0;
    it.key_col = 4'h0;
    it.key_up  = 1'b0;
    push_item(it);
    rx_push(BYTE_SMAK);
    rx_push(BYTE_RQID);
    rx_push(BYTE_UNKNOWN);
    rx_push(BYTE_ACK_LO + 8'd1);
    rx_push(BYTE_ACK_LO + 8'd2);
    it = base_item(CMD_MOUSE);
    it.buttons = 2'b00;
    it.move_x  = 8'h00;
    it.move_y  = 8'h00;
    push_item(it);
    rx_push(BYTE_HRST);
    push_item(base_item(CMD_TICK));

    for (int p = 0; p <= NSET; p++) begin
      if (p > 0) begin
        in_valid <= 1'b0;
        wait_drained();
        configure(8'(ack_set[p-1]), 8'(hs_set[p-1]), 6'(id_set[p-1]));
        if (p == 1) apb_xfer(1'b1, {REG_UNUSED, 2'b00}, $urandom);
      end
      while (sent < 25 + PHASE_ITEMS * (p + 1)) begin
        link_up();
        n = $urandom_range(12, 45);
        repeat (n) begin
          if (!held && sent >= 330) begin
            held = 1'b1;
            hold_req <= hold_req + 1;
          end
          steady <= (sent >= 560 && sent < 760);
          if (!paused && sent >= 950) begin
            paused = 1'b1;
            in_valid <= 1'b0;
            wait_drained();
          end
          push_item(rand_item());
        end
      end
    end

    in_valid <= 1'b0;
    wait_drained();
    repeat (5) @(posedge clk);
    $display("Ran %0d transactions through %0d register settings, %0d results checked.",
             sent, NSET + 1, checked);
    $display("The unit sent %0d bytes to the host and dropped %0d on a full queue.",
             bytes_sent, drops);
    if (errors == 0 && exp_left == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

>>> sim.f
+incdir+hw/rtl
hw/rtl/kmlp_pkg.sv
hw/rtl/keyboard_mouse_link_protocol_unit.sv
sim/kmlp_link_checker.sv
sim/tb.sv
